>>> sv/bvg_pkg.sv
package bvg_pkg;

  localparam int TIME_W     = 32;
  localparam int PIN_W      = 12;
  localparam int RATIO_W    = 12;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DIVIDER  = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_LOW_THR  = 2'd2,
    REG_CRIT_THR = 2'd3
  } cfg_reg_e;

  localparam logic [RATIO_W-1:0] DIVIDER_RESET  = 12'd512;
  localparam logic [MV_W-1:0]    INTERVAL_RESET = 16'd500;
  localparam logic [MV_W-1:0]    LOW_RESET      = 16'd7000;
  localparam logic [MV_W-1:0]    CRIT_RESET     = 16'd6600;

  // Discharge curve of one cell, highest voltage first.
  localparam int CURVE_POINTS = 12;
  localparam int SEG_W        = $clog2(CURVE_POINTS);

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3700,
    16'd3600, 16'd3500, 16'd3400, 16'd3300, 16'd3200, 16'd3000
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd92, 7'd82, 7'd70, 7'd58, 7'd45,
    7'd30,  7'd18, 7'd10, 7'd5,  7'd2,  7'd0
  };

  // Segment codes: a segment i spans curve points i-1 and i.
  localparam logic [SEG_W-1:0] SEG_FULL  = 4'd0;
  localparam logic [SEG_W-1:0] SEG_WIDE  = 4'd11;
  localparam logic [SEG_W-1:0] SEG_EMPTY = 4'd12;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATE,
    ST_PREP,
    ST_DIV,
    ST_SEG,
    ST_DIFF,
    ST_PCT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic gate;
    logic prep;
    logic level_from_div;
    logic seg;
    logic diff;
    logic pct;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic take;
    logic primed;
    logic div_done;
  } dp_status_t;

endpackage

>>> sv/bvg_div10.sv
module bvg_div10 #(
  parameter int NUM_W = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  // Restoring division by ten, four quotient bits per cycle.
  localparam int STEPS = (NUM_W + 3) / 4;
  localparam int PAD_W = STEPS * 4;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0] num_q, num_d, quo_q, quo_d;
  logic [3:0]       rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [4:0]       part;

  always_comb begin
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    part  = '0;
    if (cnt_q != '0) begin
      for (int j = 0; j < 4; j++) begin
        part  = {rem_d, num_d[PAD_W-1]};
        num_d = num_d << 1;
        if (part >= 5'd10) begin
          rem_d = 4'(part - 5'd10);
          quo_d = {quo_d[PAD_W-2:0], 1'b1};
        end else begin
          rem_d = part[3:0];
          quo_d = {quo_d[PAD_W-2:0], 1'b0};
        end
      end
    end
    cnt_d = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
    if (start_i) begin
      num_d = PAD_W'(num_i);
      quo_d = '0;
      rem_d = '0;
      cnt_d = CNT_W'(STEPS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = quo_q[NUM_W-1:0];

endmodule

>>> sv/bvg_datapath.sv
module bvg_datapath #(
  parameter int FRAC_W = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bvg_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [bvg_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [bvg_pkg::TIME_W-1:0]          now_ms_i,
  input  logic [bvg_pkg::PIN_W-1:0]           pin_mv_i,
  input  bvg_pkg::ctrl_cmd_t                  cmd_i,
  output bvg_pkg::dp_status_t                 status_o,
  output logic                                sample_taken_o,
  output logic [bvg_pkg::MV_W-1:0]            battery_mv_o,
  output logic [bvg_pkg::PCT_W-1:0]           charge_percent_o,
  output logic                                is_low_o,
  output logic                                is_critical_o,
  output logic                                is_primed_o
);
  import bvg_pkg::*;

  localparam int LW    = MV_W + FRAC_W;   // filtered level width
  localparam int NUM_W = LW + 4;          // 9*level + new sample
  localparam int SH    = FRAC_W + 1;      // cell mV fraction bits
  localparam int DW    = FRAC_W + 9;      // offset within one segment
  localparam int PW    = DW + 4;          // offset times percent step
  localparam int TW    = PW - SH;

  // Configuration.
  logic [RATIO_W-1:0] divider_q;
  logic [MV_W-1:0]    interval_q, low_thr_q, crit_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q  <= DIVIDER_RESET;
      interval_q <= INTERVAL_RESET;
      low_thr_q  <= LOW_RESET;
      crit_thr_q <= CRIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_DIVIDER:  divider_q  <= cfg_wdata_i[RATIO_W-1:0];
        REG_INTERVAL: interval_q <= cfg_wdata_i;
        REG_LOW_THR:  low_thr_q  <= cfg_wdata_i;
        REG_CRIT_THR: crit_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Filter state.
  logic [TIME_W-1:0] last_q;
  logic [LW-1:0]     level_q;
  logic              primed_q;

  // Working registers.
  logic [TIME_W-1:0]        now_q;
  logic [PIN_W-1:0]         pin_q;
  logic                     take_q;
  logic [PIN_W+RATIO_W-1:0] prod_q;
  logic [SEG_W-1:0]         seg_q, seg_d;
  logic [PW-1:0]            diffp_q;
  logic [PCT_W-1:0]         pct_q, pct_d;

  logic [MV_W-1:0]  pack;
  logic [LW-1:0]    packq;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quot;
  logic             div_done;
  logic             div_start;

  // The product of two 12-bit values shifted down by eight stays below 65535.
  assign pack  = prod_q[PIN_W+RATIO_W-1:8];
  assign packq = {pack, {FRAC_W{1'b0}}};
  assign num   = (NUM_W'(level_q) << 3) + NUM_W'(level_q) + NUM_W'(packq);
  assign div_start = cmd_i.prep && take_q && primed_q;

  bvg_div10 #(
    .NUM_W (NUM_W)
  ) u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      level_q  <= '0;
      primed_q <= 1'b0;
    end else begin
      if (cmd_i.prep && take_q) begin
        last_q <= now_q;
        if (!primed_q) begin
          level_q  <= packq;
          primed_q <= 1'b1;
        end
      end
      if (cmd_i.level_from_div) begin
        level_q <= quot[LW-1:0];
      end
    end
  end

  // Segment search: the first curve point at or below the level.
  always_comb begin
    seg_d = SEG_EMPTY;
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (level_q >= (LW'(CURVE_MV[i]) << SH)) begin
        seg_d = SEG_W'(i);
      end
    end
    if (level_q >= (LW'(CURVE_MV[0]) << SH)) begin
      seg_d = SEG_FULL;
    end
  end

  logic [SEG_W-1:0] sidx;
  logic [LW-1:0]    lo_level;
  logic [DW-1:0]    delta;
  logic [3:0]       dp;
  logic [TW-1:0]    t;
  logic [3:0]       q;

  assign sidx     = (seg_q == SEG_FULL || seg_q == SEG_EMPTY) ? SEG_W'(1) : seg_q;
  assign lo_level = LW'(CURVE_MV[sidx]) << SH;
  assign delta    = DW'(level_q - lo_level);
  assign dp       = 4'(CURVE_PCT[sidx - 1'b1] - CURVE_PCT[sidx]);

  // Interpolation: floor(t / span) with span 100 mV, or 200 mV on the last segment.
  always_comb begin
    t = diffp_q[PW-1:SH];
    if (seg_q == SEG_WIDE) begin
      t = t >> 1;
    end
    q = '0;
    for (int k = 3; k >= 0; k--) begin
      if (t >= TW'(100 << k)) begin
        t    = t - TW'(100 << k);
        q[k] = 1'b1;
      end
    end
    if (seg_q == SEG_FULL) begin
      pct_d = PCT_FULL;
    end else if (seg_q == SEG_EMPTY) begin
      pct_d = '0;
    end else begin
      pct_d = CURVE_PCT[sidx] + PCT_W'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q <= now_ms_i;
      pin_q <= pin_mv_i;
    end
    if (cmd_i.gate) begin
      take_q <= (now_q - last_q) >= TIME_W'(interval_q);
      prod_q <= (PIN_W+RATIO_W)'(pin_q) * (PIN_W+RATIO_W)'(divider_q);
    end
    if (cmd_i.seg) begin
      seg_q <= seg_d;
    end
    if (cmd_i.diff) begin
      diffp_q <= PW'(delta) * PW'(dp);
    end
    if (cmd_i.pct) begin
      pct_q <= pct_d;
    end
    if (cmd_i.out_load) begin
      sample_taken_o   <= take_q;
      is_primed_o      <= primed_q;
      battery_mv_o     <= primed_q ? level_q[LW-1:FRAC_W] : '0;
      charge_percent_o <= primed_q ? pct_q : '0;
      is_low_o         <= primed_q && (level_q < {low_thr_q, {FRAC_W{1'b0}}});
      is_critical_o    <= primed_q && (level_q < {crit_thr_q, {FRAC_W{1'b0}}});
    end
  end

  assign status_o.take     = take_q;
  assign status_o.primed   = primed_q;
  assign status_o.div_done = div_done;

endmodule

>>> sv/bvg_ctrl.sv
module bvg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bvg_pkg::dp_status_t status_i,
  output bvg_pkg::ctrl_cmd_t  cmd_o
);
  import bvg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_GATE;
      ST_GATE: state_d = ST_PREP;
      ST_PREP: state_d = (status_i.take && status_i.primed) ? ST_DIV : ST_SEG;
      ST_DIV:  if (status_i.div_done) state_d = ST_SEG;
      ST_SEG:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_PCT;
      ST_PCT:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_GATE: cmd_o.gate = 1'b1;
      ST_PREP: cmd_o.prep = 1'b1;
      ST_DIV:  cmd_o.level_from_div = status_i.div_done;
      ST_SEG:  cmd_o.seg = 1'b1;
      ST_DIFF: cmd_o.diff = 1'b1;
      ST_PCT:  cmd_o.pct = 1'b1;
      ST_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/battery_voltage_gauge.sv
// An accepted request passes through the gate, prepare, segment, difference and percent
// states, with the divide state between prepare and segment when the filter updates,
// and is loaded into the output register in the done state once that register is free.
// A new request is accepted only after the previous result has been loaded.
// Reset (rst_ni low, asynchronous) clears the filter, the timestamp and the primed flag,
// and returns the configuration registers to their documented defaults.
module battery_voltage_gauge #(
  parameter int FILTER_FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // now_ms[31:0], pin_mv[43:32], zero[47:44]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // sample_taken[0], battery_mv[16:1],
                                      // charge_percent[23:17], is_low[24],
                                      // is_critical[25], is_primed[26], zero[31:27]
);
  import bvg_pkg::*;

  // The design is split into a controller, which sequences each request through the
  // gate check, the scaling multiply, any filter division and the three stages of
  // curve interpolation, and a datapath, which holds every register of the filter and
  // of the configuration. The two meet only through a command and a status struct.
  // A finished result waits in the output register while the next request is taken in.

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic              sample_taken;
  logic [MV_W-1:0]   battery_mv;
  logic [PCT_W-1:0]  charge_percent;
  logic              is_low;
  logic              is_critical;
  logic              is_primed;

  bvg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath captures the request on acceptance, so the stream payload is only
  // sampled at the handshake edge.
  bvg_datapath #(
    .FRAC_W (FILTER_FRACTION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .now_ms_i         (s_axis_tdata[31:0]),
    .pin_mv_i         (s_axis_tdata[43:32]),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_taken_o   (sample_taken),
    .battery_mv_o     (battery_mv),
    .charge_percent_o (charge_percent),
    .is_low_o         (is_low),
    .is_critical_o    (is_critical),
    .is_primed_o      (is_primed)
  );

  // Result fields packed from the lowest bit up, padded to whole bytes.
  assign m_axis_tdata = {5'b0, is_primed, is_critical, is_low, charge_percent,
                         battery_mv, sample_taken};

`ifndef SYNTHESIS
  // Only one request is in flight: after an accept, the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // An unprimed result carries no voltage, percentage or flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[26] |->
      m_axis_tdata[25:1] == 25'd0)
    else $error("unprimed result carries non-zero fields");

  // The charge percentage never exceeds one hundred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:17] <= 7'd100)
    else $error("charge percentage above one hundred");

  // A result that took a sample must report a primed filter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[26])
    else $error("sample taken but filter not primed");
`endif

endmodule
